/* src/servo_slew_and_hbridge_drive_macros.svh */
// Assertion macros shared by the servo slew and H-bridge drive modules
`ifndef SERVO_SLEW_AND_HBRIDGE_DRIVE_MACROS_SVH
`define SERVO_SLEW_AND_HBRIDGE_DRIVE_MACROS_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define SHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property that also holds through reset
`define SHD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHD_ASSERT(lbl, prop, msg)
`define SHD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/shd_pkg.sv */
// Package: types, codes and constants of the servo slew and H-bridge drive block
package shd_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_SET_SPEED = 2'd0,
    CMD_SET_TURN  = 2'd1,
    CMD_SET_RUN   = 2'd2,
    CMD_TICK      = 2'd3
  } shd_cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SERVO_MIN = 2'd0,
    CFG_SERVO_MAX = 2'd1,
    CFG_SLEW_STEP = 2'd2,
    CFG_MAX_DUTY  = 2'd3
  } shd_cfg_idx_t;

  localparam int unsigned CFG_W = 12;

  // servo period in ticks and its divider width
  localparam int unsigned SERVO_PERIOD_MS = 20;
  localparam int unsigned DIV_W = 5;

  // reset values
  localparam logic [11:0] SERVO_MIN_RST = 12'd500;
  localparam logic [11:0] SERVO_MAX_RST = 12'd2400;
  localparam logic [10:0] SLEW_STEP_RST = 11'd40;
  localparam logic [7:0]  MAX_DUTY_RST  = 8'd255;
  localparam logic [9:0]  RUN_TIME_RST  = 10'd200;
  localparam logic [11:0] SERVO_MID_US  = 12'd1450;

  // setting limits
  localparam logic signed [15:0] SET_LO  = -16'sd100;
  localparam logic signed [15:0] SET_HI  = 16'sd100;
  localparam logic signed [15:0] RUN_HI  = 16'sd1000;
  localparam logic [7:0]         SET_OFS = 8'd100;
  localparam logic [9:0]         MS_SAT  = 10'd1023;

  // constant dividers: q0 = (x * RECIP) >> RECIP_SHIFT is q or q - 1
  localparam logic [8:0]  TURN_DIV    = 9'd200;
  localparam logic [16:0] TURN_RECIP  = 17'd83886;
  localparam logic [7:0]  DRV_DIV     = 8'd100;
  localparam logic [17:0] DRV_RECIP   = 18'd167772;
  localparam int unsigned RECIP_SHIFT = 24;

  // configuration as seen by the front and back parts
  typedef struct packed {
    logic [11:0] pulse_lo_us;
    logic [11:0] pulse_hi_us;
    logic [10:0] slew_step_us;
    logic [7:0]  motor_max_duty;
  } shd_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    shd_cmd_t           cmd;
    logic signed [7:0]  setting;
    logic [9:0]         run_time;
    logic [11:0]        target_us;
    logic [7:0]         fwd_duty;
    logic [7:0]         rev_duty;
  } shd_item_t;

endpackage

/* src/shd_front.sv */
// Front part: accepts items, clamps values and maps turn and speed in a pipeline
`include "servo_slew_and_hbridge_drive_macros.svh"

module shd_front import shd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  shd_cfg_t    cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        q_full,
  output logic        push,
  output shd_item_t   push_item
);

  logic                     en;
  shd_cmd_t                 in_cmd;
  logic signed [15:0]       in_val;
  logic signed [7:0]        in_set;
  logic [9:0]               in_run;
  logic signed [7:0]        spd_shadow_r;
  logic signed [7:0]        spd_shadow_nxt;

  // stage 1
  logic                     v1_r;
  shd_cmd_t                 cmd1_r;
  logic signed [7:0]        set1_r;
  logic [9:0]               run1_r;
  logic signed [7:0]        spd1_r;
  // stage 2
  logic                     v2_r;
  shd_cmd_t                 cmd2_r;
  logic signed [7:0]        set2_r;
  logic [9:0]               run2_r;
  logic                     neg2_r;
  logic [19:0]              turn_x2_r;
  logic [15:0]              drv_x2_r;
  // stage 3
  logic                     v3_r;
  shd_cmd_t                 cmd3_r;
  logic signed [7:0]        set3_r;
  logic [9:0]               run3_r;
  logic                     neg3_r;
  logic [19:0]              turn_x3_r;
  logic [11:0]              turn_q3_r;
  logic [15:0]              drv_x3_r;
  logic [8:0]               drv_q3_r;

  logic [7:0]               turn_off;
  logic [7:0]               drv_off;
  logic signed [12:0]       span;
  logic [11:0]              span_abs;
  logic [36:0]              turn_prod;
  logic [33:0]              drv_prod;
  logic [19:0]              turn_rem;
  logic [11:0]              turn_q;
  logic [15:0]              drv_rem;
  logic [8:0]               drv_q;
  logic [8:0]               duty9;

  // the whole pipeline moves while the queue has room
  assign en        = !q_full;
  assign in_tready = en;
  assign in_cmd    = shd_cmd_t'(in_tuser);
  assign in_val    = $signed(in_tdata);

  // clamp the request
  always_comb begin
    if (in_val < SET_LO) begin
      in_set = SET_LO[7:0];
    end else if (in_val > SET_HI) begin
      in_set = SET_HI[7:0];
    end else begin
      in_set = in_val[7:0];
    end
    if (in_val < 16'sd0) begin
      in_run = '0;
    end else if (in_val > RUN_HI) begin
      in_run = RUN_HI[9:0];
    end else begin
      in_run = in_val[9:0];
    end
  end

  // in-order copy of the speed setting, so every item carries its duty
  always_comb begin
    spd_shadow_nxt = spd_shadow_r;
    if (in_tvalid && en && in_cmd == CMD_SET_SPEED) begin
      spd_shadow_nxt = in_set;
    end
  end

  // stage 2 operands: offsets and servo span
  assign turn_off = $unsigned(set1_r) + SET_OFS;
  assign drv_off  = $unsigned(spd1_r) + SET_OFS;
  assign span     = $signed({1'b0, cfg.pulse_hi_us}) - $signed({1'b0, cfg.pulse_lo_us});
  assign span_abs = span[12] ? 12'(-span) : span[11:0];

  // stage 3: reciprocal multiplies
  assign turn_prod = 37'(turn_x2_r) * 37'(TURN_RECIP);
  assign drv_prod  = 34'(drv_x2_r) * 34'(DRV_RECIP);

  // after stage 3: one correction step on each quotient
  always_comb begin
    turn_rem = turn_x3_r - 20'(turn_q3_r) * 20'(TURN_DIV);
    turn_q   = turn_q3_r + 12'(turn_rem >= 20'(TURN_DIV));
    drv_rem  = drv_x3_r - 16'(drv_q3_r) * 16'(DRV_DIV);
    drv_q    = drv_q3_r + 9'(drv_rem >= 16'(DRV_DIV));

    push_item.cmd       = cmd3_r;
    push_item.setting   = set3_r;
    push_item.run_time  = run3_r;
    push_item.target_us = neg3_r ? cfg.pulse_lo_us - turn_q : cfg.pulse_lo_us + turn_q;
    duty9               = {1'b0, cfg.motor_max_duty};
    if (drv_q >= duty9) begin
      push_item.fwd_duty = 8'(drv_q - duty9);
      push_item.rev_duty = '0;
    end else begin
      push_item.fwd_duty = '0;
      push_item.rev_duty = 8'(duty9 - drv_q);
    end
  end

  assign push = en && v3_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_shadow_r <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
    end else begin
      spd_shadow_r <= spd_shadow_nxt;
      if (en) begin
        v1_r <= in_tvalid;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r    <= in_cmd;
      set1_r    <= in_set;
      run1_r    <= in_run;
      spd1_r    <= (in_cmd == CMD_SET_SPEED) ? in_set : spd_shadow_r;

      cmd2_r    <= cmd1_r;
      set2_r    <= set1_r;
      run2_r    <= run1_r;
      neg2_r    <= span[12];
      turn_x2_r <= 20'(turn_off) * 20'(span_abs);
      drv_x2_r  <= 16'(drv_off) * 16'(cfg.motor_max_duty);

      cmd3_r    <= cmd2_r;
      set3_r    <= set2_r;
      run3_r    <= run2_r;
      neg3_r    <= neg2_r;
      turn_x3_r <= turn_x2_r;
      turn_q3_r <= turn_prod[RECIP_SHIFT +: 12];
      drv_x3_r  <= drv_x2_r;
      drv_q3_r  <= drv_prod[RECIP_SHIFT +: 9];
    end
  end

  // reciprocal estimate is never more than one short
  `SHD_ASSERT(a_div_one_step, v3_r |-> (turn_rem < 20'(2 * TURN_DIV) && drv_rem < 16'(2 * DRV_DIV)), "front: quotient estimate off by more than one")

endmodule

/* src/shd_queue.sv */
// Short item queue between the front and back parts
`include "servo_slew_and_hbridge_drive_macros.svh"

module shd_queue import shd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  shd_item_t push_item,
  input  logic      pop,
  output shd_item_t pop_item,
  output logic      full,
  output logic      empty
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  shd_item_t          slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;

  assign full     = (count_r == (PTR_W + 1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and count stay consistent
  `SHD_ASSERT(a_ptr_count, (wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0], "queue: pointers disagree with count")
  `SHD_ASSERT(a_no_underflow, pop |-> !empty, "queue: pop from empty queue")

endmodule

/* src/shd_back.sv */
// Back part: applies items to the servo and motor state and registers the result
`include "servo_slew_and_hbridge_drive_macros.svh"

module shd_back import shd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  shd_cfg_t    cfg,
  input  logic        q_empty,
  input  shd_item_t   q_item,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [11:0] servo_pulse_us, [19:12] motor_fwd_duty,
                                  // [27:20] motor_rev_duty, [28] command_active,
                                  // [36:29] speed_now, [44:37] turn_now,
                                  // [54:45] run_time_now, [55] zero
);

  logic signed [7:0]  speed_r, speed_nxt;
  logic signed [7:0]  turn_r, turn_nxt;
  logic [9:0]         run_r, run_nxt;
  logic [11:0]        target_r, target_nxt;
  logic [11:0]        cur_r, cur_nxt;
  logic [9:0]         ms_r, ms_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [DIV_W:0]     div_sum;
  logic [11:0]        diff;
  logic [11:0]        step12;
  logic [11:0]        move;
  logic               out_valid_r, out_valid_nxt;
  logic [55:0]        out_data_r, out_data_nxt;

  assign pop        = !q_empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign step12     = {1'b0, cfg.slew_step_us};

  // state update for the popped item
  always_comb begin
    speed_nxt  = speed_r;
    turn_nxt   = turn_r;
    run_nxt    = run_r;
    target_nxt = target_r;
    cur_nxt    = cur_r;
    ms_nxt     = ms_r;
    div_nxt    = div_r;
    div_sum    = (DIV_W + 1)'(div_r) + 1'b1;
    diff       = '0;
    move       = '0;
    if (pop) begin
      unique case (q_item.cmd)
        CMD_SET_SPEED: begin
          speed_nxt = q_item.setting;
          ms_nxt    = '0;
        end
        CMD_SET_TURN: begin
          turn_nxt   = q_item.setting;
          target_nxt = q_item.target_us;
          ms_nxt     = '0;
        end
        CMD_SET_RUN: begin
          run_nxt = q_item.run_time;
        end
        CMD_TICK: begin
          if (ms_r != MS_SAT) begin
            ms_nxt = ms_r + 1'b1;
          end
          if (div_sum >= (DIV_W + 1)'(SERVO_PERIOD_MS)) begin
            div_nxt = '0;
            // one slew step toward the target
            if (cur_r < target_r) begin
              diff    = target_r - cur_r;
              move    = (diff < step12) ? diff : step12;
              cur_nxt = cur_r + move;
            end else if (cur_r > target_r) begin
              diff    = cur_r - target_r;
              move    = (diff < step12) ? diff : step12;
              cur_nxt = cur_r - move;
            end
          end else begin
            div_nxt = div_sum[DIV_W-1:0];
          end
        end
        default: begin
          ms_nxt = ms_r;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, run_nxt, turn_nxt, speed_nxt, (ms_nxt < run_nxt),
                       q_item.rev_duty, q_item.fwd_duty, cur_nxt};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      turn_r      <= '0;
      run_r       <= RUN_TIME_RST;
      target_r    <= SERVO_MID_US;
      cur_r       <= SERVO_MID_US;
      ms_r        <= '0;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      speed_r     <= speed_nxt;
      turn_r      <= turn_nxt;
      run_r       <= run_nxt;
      target_r    <= target_nxt;
      cur_r       <= cur_nxt;
      ms_r        <= ms_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // the pulse only moves on a tick item
  `SHD_ASSERT(a_slew_on_tick, ($past(rst_n) && cur_r != $past(cur_r)) |-> ($past(pop) && $past(q_item.cmd) == CMD_TICK), "back: servo pulse moved without a tick")
  // the period divider wraps before the servo period
  `SHD_ASSERT(a_div_range, div_r < DIV_W'(SERVO_PERIOD_MS), "back: period divider out of range")

endmodule

/* src/servo_slew_and_hbridge_drive.sv */
// Top level: configuration registers and the front, queue and back parts
//
// Takes one item per clock while the queue has room: a set-speed, set-turn or
// set-run-time command, or a one-millisecond tick, and returns one result per item
// with the slewed servo pulse, the forward and reverse H-bridge duties, the active
// flag and the held settings. A new item is accepted every cycle while the queue is
// not full; each result passes through three pipeline stages that clamp the value
// and map turn and speed through a multiply and a reciprocal divide, the
// four-entry queue, and the output register. Back-pressure on the result side
// fills the queue before the input stalls. Configuration writes take effect at
// once and are meant to be made while no item is in flight.

module servo_slew_and_hbridge_drive import shd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // item input
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // [15:0] value
  input  logic [1:0]       in_tuser,   // [1:0] command
  // result output
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata   // [11:0] servo_pulse_us, [19:12] motor_fwd_duty,
                                       // [27:20] motor_rev_duty, [28] command_active,
                                       // [36:29] speed_now, [44:37] turn_now,
                                       // [54:45] run_time_now, [55] zero
);

  shd_cfg_t  cfg_r, cfg_nxt;
  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  shd_item_t push_item;
  shd_item_t pop_item;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (shd_cfg_idx_t'(cfg_index))
        CFG_SERVO_MIN: cfg_nxt.pulse_lo_us    = cfg_wdata[11:0];
        CFG_SERVO_MAX: cfg_nxt.pulse_hi_us    = cfg_wdata[11:0];
        CFG_SLEW_STEP: cfg_nxt.slew_step_us   = cfg_wdata[10:0];
        CFG_MAX_DUTY:  cfg_nxt.motor_max_duty = cfg_wdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_lo_us    <= SERVO_MIN_RST;
      cfg_r.pulse_hi_us    <= SERVO_MAX_RST;
      cfg_r.slew_step_us   <= SLEW_STEP_RST;
      cfg_r.motor_max_duty <= MAX_DUTY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  shd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  shd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  shd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
